// ===== hw/rtl/crev8_pkg.sv =====
// Shared types and constants for the eight-line comb reverb.
// Holds the item structs, register indexes, op kinds and the delay factor table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package crev8_pkg;

  // sample and line geometry
  localparam int SAMPLE_W     = 32;
  localparam int LINE_COUNT   = 8;
  localparam int LINE_W       = 3;
  localparam int SAMPLE_SHIFT = 3;
  localparam int FB_SHIFT     = 7;

  // feedback gain
  localparam int              FB_W      = 7;
  localparam logic [FB_W-1:0] FB_STEREO = 7'd63;
  localparam logic [FB_W-1:0] FB_MONO   = 7'd58;

  // configuration registers
  localparam int                    LEVEL_W     = 4;
  localparam int                    FREQ_W      = 16;
  localparam int                    CFG_INDEX_W = 2;
  localparam int                    CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] REG_LEVEL  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_STEREO = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_FREQ   = 2'd2;
  localparam logic [FREQ_W-1:0]      FREQ_RESET = 16'd44100;

  // input commands
  localparam logic CMD_STOP = 1'b1;

  // line length computation: factor * freq / 110000, done as
  // ((factor * freq) >> 4) / 6875 with a reciprocal multiply, exact below 2^30
  localparam int                 FACTOR_W      = 14;
  localparam int                 PROD_W        = 30;
  localparam int                 QUO_W         = 13;
  localparam int                 DIV_PRE_SHIFT = 4;
  localparam int                 RECIP_W       = 27;
  localparam logic [RECIP_W-1:0] RECIP         = 27'd79964483;
  localparam int                 RECIP_SHIFT   = 39;

  // what an accepted item does
  typedef enum logic [1:0] {
    OP_FRAME,
    OP_BYPASS,
    OP_STOP
  } op_kind_t;

  typedef struct packed {
    logic                       command;
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
  } out_item_t;

  // delay factor of each line
  function automatic logic [FACTOR_W-1:0] line_factor(input logic [LINE_W-1:0] idx);
    logic [FACTOR_W-1:0] f;
    case (idx)
      3'd0:    f = 14'd5000;
      3'd1:    f = 14'd5078;
      3'd2:    f = 14'd5313;
      3'd3:    f = 14'd5703;
      3'd4:    f = 14'd6250;
      3'd5:    f = 14'd6953;
      3'd6:    f = 14'd7813;
      3'd7:    f = 14'd8828;
      default: f = 14'd5000;
    endcase
    return f;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/comb_reverb_eight_line_top.sv =====
// Eight-line feedback comb reverb, top level.
// Holds the line memories, the per-line engine, the length unit and the clear sweep.
// Depends on crev8_pkg.
//
// One stereo (or mono) frame per input transfer. Each channel keeps eight feedback
// delay lines in one memory (one write and one read port); a frame walks the eight
// lines one per cycle while the output is not stalled, and the next frame is taken
// as the current one walks its last line. A level-0 frame and a stop item hold the
// front stage alone, so the next transfer is taken once they have left it. After
// reset, and after a stop, a level-0 frame or a frequency write that follows frames
// with reverb on, a clear sweep zeroes both memories (8 * 2^ceil(log2(MAX_DELAY))
// entries, 32768 at the default) at one address per cycle with input held off.
// Reset and each frequency write also recompute the eight line lengths, input held
// off. Configuration writes are taken at any time, and belong where no item is in
// flight.
`timescale 1ns / 1ps
`default_nettype none

module comb_reverb_eight_line_top #(
  parameter int MAX_DELAY = 4096
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  crev8_pkg::in_item_t                     in_data,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output crev8_pkg::out_item_t                    out_data,
  input  logic                                    cfg_write,
  input  logic [crev8_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [crev8_pkg::CFG_DATA_W-1:0]        cfg_data
);

  localparam int SW     = crev8_pkg::SAMPLE_W;
  localparam int LW     = crev8_pkg::LINE_W;
  localparam int POS_W  = $clog2(MAX_DELAY);
  localparam int LEN_W  = $clog2(MAX_DELAY + 1);
  localparam int ADDR_W = LW + POS_W;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam int PW     = crev8_pkg::PROD_W;
  localparam int QW     = crev8_pkg::QUO_W;
  localparam int DW     = PW - crev8_pkg::DIV_PRE_SHIFT;
  localparam int RW     = crev8_pkg::RECIP_W;
  localparam int MW     = SW + crev8_pkg::FB_W + 1;
  localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_DELAY);
  localparam logic [LW-1:0]    LAST_LINE = LW'(crev8_pkg::LINE_COUNT - 1);

  // configuration registers
  logic [crev8_pkg::LEVEL_W-1:0] reverb_level;
  logic                          stereo_mode;
  logic [crev8_pkg::FREQ_W-1:0]  mixer_freq;
  logic                          freq_write;

  // front stage: one line per cycle unless stalled
  logic                        a_valid;
  crev8_pkg::op_kind_t         a_kind;
  logic [LW-1:0]               a_line;
  logic [crev8_pkg::FB_W-1:0]  a_fb;
  logic                        a_stereo;
  logic signed [SW-1:0]        a_left;
  logic signed [SW-1:0]        a_right;
  logic                        a_last;
  logic                        a_frame_go;

  // back stage: read data returns
  logic                        b_valid;
  crev8_pkg::op_kind_t         b_kind;
  logic [LW-1:0]               b_line;
  logic                        b_last;
  logic                        b_fwd;
  logic                        b_stereo;
  logic signed [SW-1:0]        b_new_l;
  logic signed [SW-1:0]        b_new_r;
  logic signed [SW-1:0]        b_left;
  logic signed [SW-1:0]        b_right;
  logic                        b_emit;
  logic                        b_frame_go;

  // line state
  logic [POS_W-1:0]            positions [crev8_pkg::LINE_COUNT];
  logic [LEN_W-1:0]            lengths   [crev8_pkg::LINE_COUNT];
  logic signed [SW-1:0]        cur_l     [crev8_pkg::LINE_COUNT];
  logic signed [SW-1:0]        cur_r     [crev8_pkg::LINE_COUNT];
  logic signed [SW-1:0]        acc_l;
  logic signed [SW-1:0]        acc_r;

  // memories
  logic signed [SW-1:0]        left_mem  [DEPTH];
  logic signed [SW-1:0]        right_mem [DEPTH];
  logic signed [SW-1:0]        left_rdata;
  logic signed [SW-1:0]        right_rdata;
  logic                        mem_we_l;
  logic                        mem_we_r;
  logic                        mem_re;
  logic [ADDR_W-1:0]           mem_waddr;
  logic [ADDR_W-1:0]           mem_raddr;
  logic signed [SW-1:0]        mem_wdata_l;
  logic signed [SW-1:0]        mem_wdata_r;

  // clear sweep
  logic                        sweeping;
  logic [ADDR_W-1:0]           sweep_addr;
  logic                        dirty;
  logic                        clear_now;

  // length unit
  logic                        len_busy;
  logic                        len_load;
  logic [LW-1:0]               len_line;
  logic [PW-1:0]               len_rem;
  logic [DW+RW-1:0]            recip_prod;
  logic [QW-1:0]               quo_final;
  logic [LEN_W-1:0]            len_clamped;
  logic                        len_done;

  // handshake and flow
  logic                        in_fire;
  crev8_pkg::op_kind_t         in_kind;
  logic [crev8_pkg::FB_W-1:0]  in_fb;
  logic                        stall;
  logic                        adv;

  // front stage datapath
  logic [POS_W-1:0]            pos_cur;
  logic [LEN_W-1:0]            len_cur;
  logic [LEN_W-1:0]            pos_inc;
  logic [POS_W-1:0]            pos_nxt;
  logic                        fwd;
  logic signed [MW-1:0]        prod_l;
  logic signed [MW-1:0]        prod_r;
  logic signed [SW-1:0]        new_l;
  logic signed [SW-1:0]        new_r;

  // back stage datapath
  logic signed [SW-1:0]        v_l;
  logic signed [SW-1:0]        v_r;
  logic signed [SW-1:0]        sum_l_next;
  logic signed [SW-1:0]        sum_r_next;
  crev8_pkg::out_item_t        result;

  // configuration writes
  assign freq_write = cfg_write && (cfg_index == crev8_pkg::REG_FREQ);

  always_ff @(posedge clk) begin
    if (rst) begin
      reverb_level <= '0;
      stereo_mode  <= 1'b1;
      mixer_freq   <= crev8_pkg::FREQ_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        crev8_pkg::REG_LEVEL:  reverb_level <= cfg_data[crev8_pkg::LEVEL_W-1:0];
        crev8_pkg::REG_STEREO: stereo_mode  <= cfg_data[0];
        crev8_pkg::REG_FREQ:   mixer_freq   <= cfg_data;
        default: ;
      endcase
    end
  end

  // input decode
  always_comb begin
    if (in_data.command == crev8_pkg::CMD_STOP) begin
      in_kind = crev8_pkg::OP_STOP;
    end else if (reverb_level == '0) begin
      in_kind = crev8_pkg::OP_BYPASS;
    end else begin
      in_kind = crev8_pkg::OP_FRAME;
    end
    in_fb = (stereo_mode ? crev8_pkg::FB_STEREO : crev8_pkg::FB_MONO)
            + crev8_pkg::FB_W'({reverb_level, 2'b00});
  end

  // flow control: a finished result waits in the output register
  assign b_emit = b_valid && ((b_kind == crev8_pkg::OP_FRAME && b_last)
                              || b_kind == crev8_pkg::OP_BYPASS);
  assign stall  = b_emit && out_valid && !out_ready;
  assign adv    = !stall;
  assign a_last = (a_kind != crev8_pkg::OP_FRAME) || (a_line == LAST_LINE);
  assign a_frame_go = a_valid && (a_kind == crev8_pkg::OP_FRAME) && adv;
  assign b_frame_go = b_valid && (b_kind == crev8_pkg::OP_FRAME) && adv;
  assign clear_now  = (a_valid && (a_kind != crev8_pkg::OP_FRAME) && adv) || freq_write;

  assign in_ready = !sweeping && !len_busy
                    && (!a_valid || (a_kind == crev8_pkg::OP_FRAME && a_last && adv));
  assign in_fire  = in_valid && in_ready;

  // front stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      a_line  <= '0;
      a_kind  <= crev8_pkg::OP_STOP;
    end else if (in_fire) begin
      a_valid <= 1'b1;
      a_kind  <= in_kind;
      a_line  <= '0;
    end else if (a_valid && adv) begin
      if (a_last) begin
        a_valid <= 1'b0;
      end else begin
        a_line <= a_line + 1'b1;
      end
    end
  end

  // front stage payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_fb     <= in_fb;
      a_stereo <= stereo_mode;
      a_left   <= in_data.left_sample;
      a_right  <= in_data.right_sample;
    end
  end

  // position advance and feedback update for the current line
  always_comb begin
    pos_cur = positions[a_line];
    len_cur = lengths[a_line];
    pos_inc = LEN_W'(pos_cur) + LEN_W'(1);
    pos_nxt = (pos_inc >= len_cur) ? '0 : pos_inc[POS_W-1:0];
    fwd     = (pos_nxt == pos_cur);
    prod_l  = MW'($signed({1'b0, a_fb})) * MW'(cur_l[a_line]);
    prod_r  = MW'($signed({1'b0, a_fb})) * MW'(cur_r[a_line]);
    new_l   = (a_left >>> crev8_pkg::SAMPLE_SHIFT)
              + SW'(prod_l >>> crev8_pkg::FB_SHIFT);
    new_r   = (a_right >>> crev8_pkg::SAMPLE_SHIFT)
              + SW'(prod_r >>> crev8_pkg::FB_SHIFT);
  end

  // memory port selection: sweep or engine
  always_comb begin
    mem_re      = a_frame_go;
    mem_raddr   = {a_line, pos_nxt};
    mem_we_l    = sweeping || a_frame_go;
    mem_we_r    = sweeping || (a_frame_go && a_stereo);
    mem_waddr   = sweeping ? sweep_addr : {a_line, pos_cur};
    mem_wdata_l = sweeping ? '0 : new_l;
    mem_wdata_r = sweeping ? '0 : new_r;
  end

  // line memories
  always_ff @(posedge clk) begin
    if (mem_we_l) begin
      left_mem[mem_waddr] <= mem_wdata_l;
    end
    if (mem_re) begin
      left_rdata <= left_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we_r) begin
      right_mem[mem_waddr] <= mem_wdata_r;
    end
    if (mem_re) begin
      right_rdata <= right_mem[mem_raddr];
    end
  end

  // line positions
  always_ff @(posedge clk) begin
    if (rst || clear_now) begin
      positions <= '{default: '0};
    end else if (a_frame_go) begin
      positions[a_line] <= pos_nxt;
    end
  end

  // back stage registers
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      b_kind  <= crev8_pkg::OP_STOP;
      b_line  <= '0;
      b_last  <= 1'b0;
    end else if (adv) begin
      b_valid <= a_valid;
      b_kind  <= a_kind;
      b_line  <= a_line;
      b_last  <= a_last;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_fwd    <= fwd;
      b_stereo <= a_stereo;
      b_new_l  <= new_l;
      b_new_r  <= new_r;
      b_left   <= a_left;
      b_right  <= a_right;
    end
  end

  // entry at the new position, forwarded when the line is one entry long
  always_comb begin
    v_l = b_fwd ? b_new_l : left_rdata;
    v_r = (b_fwd && b_stereo) ? b_new_r : right_rdata;
    if (b_line[0]) begin
      sum_l_next = ((b_line == '0) ? '0 : acc_l) - v_l;
      sum_r_next = ((b_line == '0) ? '0 : acc_r) - v_r;
    end else begin
      sum_l_next = ((b_line == '0) ? '0 : acc_l) + v_l;
      sum_r_next = ((b_line == '0) ? '0 : acc_r) + v_r;
    end
    if (b_kind == crev8_pkg::OP_FRAME) begin
      result.left_out  = b_left + sum_l_next;
      result.right_out = b_stereo ? (b_right + sum_r_next) : '0;
    end else begin
      result.left_out  = b_left;
      result.right_out = b_stereo ? b_right : '0;
    end
  end

  // current entry of each line and tap accumulators
  always_ff @(posedge clk) begin
    if (rst || clear_now) begin
      cur_l <= '{default: '0};
      cur_r <= '{default: '0};
    end else if (b_frame_go) begin
      cur_l[b_line] <= v_l;
      cur_r[b_line] <= v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_frame_go) begin
      acc_l <= sum_l_next;
      acc_r <= sum_r_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_emit && adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_emit && adv) begin
      out_data <= result;
    end
  end

  // clear sweep, run after reset and otherwise only when lines hold data
  always_ff @(posedge clk) begin
    if (rst) begin
      sweeping   <= 1'b1;
      sweep_addr <= '0;
      dirty      <= 1'b0;
    end else begin
      if (in_fire && in_kind == crev8_pkg::OP_FRAME) begin
        dirty <= 1'b1;
      end
      if (clear_now && dirty) begin
        sweeping   <= 1'b1;
        sweep_addr <= '0;
        dirty      <= 1'b0;
      end else if (sweeping) begin
        sweep_addr <= sweep_addr + 1'b1;
        if (sweep_addr == '1) begin
          sweeping <= 1'b0;
        end
      end
    end
  end

  // length unit: product registered, reciprocal multiply and clamp in the next cycle
  always_comb begin
    recip_prod = (DW + RW)'(len_rem[PW-1:crev8_pkg::DIV_PRE_SHIFT])
                 * (DW + RW)'(crev8_pkg::RECIP);
    quo_final  = recip_prod[crev8_pkg::RECIP_SHIFT +: QW];
    len_done   = len_busy && !len_load;
    if (quo_final == '0) begin
      len_clamped = LEN_W'(1);
    end else if ((QW + 1)'(quo_final) > (QW + 1)'(MAX_DELAY)) begin
      len_clamped = LEN_MAX;
    end else begin
      len_clamped = LEN_W'(quo_final);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || freq_write) begin
      len_busy <= 1'b1;
      len_load <= 1'b1;
      len_line <= '0;
    end else if (len_busy) begin
      if (len_load) begin
        len_load <= 1'b0;
      end else if (len_line == LAST_LINE) begin
        len_busy <= 1'b0;
      end else begin
        len_line <= len_line + 1'b1;
        len_load <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (len_busy && len_load) begin
      len_rem <= PW'(crev8_pkg::line_factor(len_line)) * PW'(mixer_freq);
    end
  end

  always_ff @(posedge clk) begin
    if (len_done) begin
      lengths[len_line] <= len_clamped;
    end
  end

  // checks on the engine
  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    (a_valid && a_kind == crev8_pkg::OP_FRAME) |-> (LEN_W'(pos_cur) < len_cur))
    else $error("line position not below line length");

  a_fwd_len_one: assert property (@(posedge clk) disable iff (rst)
    (a_frame_go && fwd) |-> (len_cur == LEN_W'(1)))
    else $error("same-entry forward on a line longer than one");

  a_no_frame_in_sweep: assert property (@(posedge clk) disable iff (rst)
    sweeping |-> !(a_valid && a_kind == crev8_pkg::OP_FRAME)
                 && !(b_valid && b_kind == crev8_pkg::OP_FRAME))
    else $error("frame in flight during clear sweep");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    stall |=> (b_emit && $stable(b_line) && out_valid))
    else $error("stalled result lost");

  a_emit_lands: assert property (@(posedge clk) disable iff (rst)
    (b_emit && adv) |=> out_valid)
    else $error("emitted result not in output register");

endmodule

`default_nettype wire

// ===== tb/sv/reverb_frame_checker.sv =====
// Checker for the eight-line comb reverb: watches the config port and both channels.
// Predicts each frame's result from its own copy of the lines and compares field by field.
// Depends on crev8_pkg.
`timescale 1ns / 1ps

module reverb_frame_checker #(
  parameter int MAX_DELAY = 4096
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  crev8_pkg::in_item_t               in_data,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  crev8_pkg::out_item_t              out_data,
  input  logic                              cfg_write,
  input  logic [crev8_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [crev8_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                                fail_count,
  output int                                open_count
);
  import crev8_pkg::*;

  localparam int          LINES          = 8;
  localparam int unsigned LENGTH_DIVISOR = 110000;
  localparam logic [7:0]  GAIN_STEREO    = 8'd63;
  localparam logic [7:0]  GAIN_MONO      = 8'd58;
  localparam int          INPUT_SHIFT    = 3;
  localparam int          GAIN_SHIFT     = 7;

  // mirrored registers
  logic [3:0]  level_r;
  logic        stereo_r;
  logic [15:0] freq_r;

  // mirrored delay lines, line i at offset i * MAX_DELAY
  logic [31:0] left_mem  [LINES*MAX_DELAY];
  logic [31:0] right_mem [LINES*MAX_DELAY];
  int unsigned line_len  [LINES];
  int unsigned line_pos  [LINES];
  bit          mem_dirty;

  out_item_t expected_frames[$];
  int        errors;

  function automatic int unsigned delay_factor(input int i);
    case (i)
      0:       return 5000;
      1:       return 5078;
      2:       return 5313;
      3:       return 5703;
      4:       return 6250;
      5:       return 6953;
      6:       return 7813;
      default: return 8828;
    endcase
  endfunction

  // line lengths from the sample rate, at least 1 and at most MAX_DELAY
  task automatic recompute_lengths();
    int unsigned len;
    for (int i = 0; i < LINES; i++) begin
      len = (delay_factor(i) * int'(freq_r)) / LENGTH_DIVISOR;
      if (len == 0) len = 1;
      if (len > MAX_DELAY) len = MAX_DELAY;
      line_len[i] = len;
    end
  endtask

  task automatic clear_lines();
    if (mem_dirty) begin
      for (int k = 0; k < LINES*MAX_DELAY; k++) begin
        left_mem[k]  = '0;
        right_mem[k] = '0;
      end
      mem_dirty = 0;
    end
    for (int i = 0; i < LINES; i++) line_pos[i] = 0;
  endtask

  // new entry: shifted input plus (gain * old entry) >> 7 with an exact product
  function automatic logic [31:0] comb_next(input logic [31:0] entry,
                                            input logic [31:0] shifted,
                                            input logic [7:0]  gain);
    longint ext;
    longint product;
    ext     = longint'($signed(entry));
    product = longint'(gain) * ext;
    product = product >>> GAIN_SHIFT;
    return shifted + product[31:0];
  endfunction

  task automatic feed_channel(input bit right_side, input logic [31:0] sample,
                              input logic [7:0] gain);
    logic [31:0] shifted;
    int          idx;
    shifted = $signed(sample) >>> INPUT_SHIFT;
    for (int i = 0; i < LINES; i++) begin
      idx = i * MAX_DELAY + int'(line_pos[i]);
      if (right_side) right_mem[idx] = comb_next(right_mem[idx], shifted, gain);
      else            left_mem[idx]  = comb_next(left_mem[idx], shifted, gain);
    end
  endtask

  // alternating-sign sum of the eight taps
  function automatic logic [31:0] tap_sum(input bit right_side);
    logic [31:0] acc;
    logic [31:0] tap;
    acc = '0;
    for (int i = 0; i < LINES; i++) begin
      tap = right_side ? right_mem[i * MAX_DELAY + int'(line_pos[i])]
                       : left_mem[i * MAX_DELAY + int'(line_pos[i])];
      acc = (i % 2 == 1) ? acc - tap : acc + tap;
    end
    return acc;
  endfunction

  task automatic apply_write(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
    case (idx)
      REG_LEVEL:  level_r  = value[3:0];
      REG_STEREO: stereo_r = value[0];
      REG_FREQ: begin
        freq_r = value;
        recompute_lengths();
        clear_lines();
      end
      default: ;
    endcase
  endtask

  // one accepted input transfer
  task automatic predict_frame(input in_item_t item);
    out_item_t   want;
    logic [7:0]  gain;
    logic [31:0] left;
    logic [31:0] right;
    left  = item.left_sample;
    right = item.right_sample;
    if (item.command == CMD_STOP) begin
      clear_lines();
      return;
    end
    if (level_r == 0) begin
      clear_lines();
      want.left_out  = left;
      want.right_out = stereo_r ? right : '0;
      expected_frames.push_back(want);
      return;
    end
    gain      = (stereo_r ? GAIN_STEREO : GAIN_MONO) + {2'b00, level_r, 2'b00};
    mem_dirty = 1;
    feed_channel(0, left, gain);
    if (stereo_r) feed_channel(1, right, gain);
    for (int i = 0; i < LINES; i++)
      line_pos[i] = (line_pos[i] + 1 >= line_len[i]) ? 0 : line_pos[i] + 1;
    want.left_out  = left + tap_sum(0);
    want.right_out = stereo_r ? right + tap_sum(1) : '0;
    expected_frames.push_back(want);
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (expected_frames.size() == 0) begin
      $error("result with no frame pending: left_out %0d right_out %0d",
             got.left_out, got.right_out);
      errors++;
      return;
    end
    want = expected_frames.pop_front();
    if (got.left_out !== want.left_out) begin
      $error("left_out mismatch: expected %0d, actual %0d", want.left_out, got.left_out);
      errors++;
    end
    if (got.right_out !== want.right_out) begin
      $error("right_out mismatch: expected %0d, actual %0d", want.right_out, got.right_out);
      errors++;
    end
  endtask

  // results are checked before new frames are predicted in the same cycle
  always @(posedge clk) begin
    if (rst) begin
      level_r   = '0;
      stereo_r  = 1'b1;
      freq_r    = 16'd44100;
      mem_dirty = 1;
      clear_lines();
      recompute_lengths();
      expected_frames.delete();
      errors    = 0;
    end else begin
      if (cfg_write) apply_write(cfg_index, cfg_data);
      if (out_valid && out_ready) check_result(out_data);
      if (in_valid && in_ready) predict_frame(in_data);
    end
    fail_count <= errors;
    open_count <= expected_frames.size();
  end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the reverb testbench: clock, reset, stimulus, receiver stalls and verdict.
// Instantiates comb_reverb_eight_line_top and reverb_frame_checker; depends on crev8_pkg.
`timescale 1ns / 1ps

module testbench;
  import crev8_pkg::*;

  localparam int          MAX_DELAY   = 4096;
  localparam int          SWEEP_WAIT  = 8 * MAX_DELAY + 512;
  localparam int          SETTLE_WAIT = 16;
  localparam int          TAIL_WAIT   = 64;
  localparam int          CYCLE_LIMIT = 3_000_000;
  localparam logic        CMD_FRAME   = 1'b0;
  localparam logic [31:0] SAMPLE_MAX  = 32'h7FFF_FFFF;
  localparam logic [31:0] SAMPLE_MIN  = 32'h8000_0000;

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_ready;
  in_item_t               in_data;
  logic                   out_valid;
  logic                   out_ready;
  out_item_t              out_data;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  int                     fail_count;
  int                     open_count;

  int          send_idle_pct;
  int          recv_idle_pct;
  int          stops_left;
  int          cycle_count;
  logic [3:0]  cur_level;
  bit          lines_dirty;
  bit          sweep_may_run;

  comb_reverb_eight_line_top #(.MAX_DELAY(MAX_DELAY)) u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  reverb_frame_checker #(.MAX_DELAY(MAX_DELAY)) u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .open_count (open_count)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver stalls
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // run limit
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  function automatic in_item_t make_item(input logic cmd, input logic [31:0] left,
                                         input logic [31:0] right);
    in_item_t item;
    item.command      = cmd;
    item.left_sample  = left;
    item.right_sample = right;
    return item;
  endfunction

  // extremes, small values around zero, and full-range noise
  function automatic logic [31:0] pick_sample();
    case ($urandom_range(9))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2, 3:    return 32'($urandom_range(2000)) - 32'd1000;
      default: return $urandom;
    endcase
  endfunction

  // one input transfer, with random gaps before it
  task automatic send_item(input in_item_t item);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = item;
    do @(posedge clk); while (!in_ready);
    // stop and bypass frames start a clear sweep when the lines hold data
    if (item.command == CMD_STOP || cur_level == 0) begin
      if (lines_dirty) sweep_may_run = 1;
      lines_dirty = 0;
    end else begin
      lines_dirty   = 1;
      sweep_may_run = 0;
    end
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    in_valid = 1'b0;
    do @(posedge clk); while (open_count != 0);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  // registers change only once the block is idle
  task automatic configure(input logic [3:0] level, input logic stereo,
                           input logic [15:0] freq, input bit set_freq);
    hold_until_drained();
    if (sweep_may_run) repeat (SWEEP_WAIT) @(posedge clk);
    else repeat (SETTLE_WAIT) @(posedge clk);
    sweep_may_run = 0;
    write_reg(REG_LEVEL, 16'(level));
    write_reg(REG_STEREO, 16'(stereo));
    if (set_freq) begin
      write_reg(REG_FREQ, freq);
      lines_dirty = 0;
    end
    cur_level = level;
  endtask

  task automatic random_frames(input int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(149) == 0) hold_until_drained();
      if (stops_left > 0 && $urandom_range(199) == 0) begin
        stops_left--;
        send_item(make_item(CMD_STOP, pick_sample(), pick_sample()));
      end else begin
        send_item(make_item(CMD_FRAME, pick_sample(), pick_sample()));
      end
    end
  endtask

  task automatic set_idling(input int sender_pct, input int receiver_pct);
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
  endtask

  // stimulus and verdict
  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    in_data       = '0;
    cfg_write     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    send_idle_pct = 13;
    recv_idle_pct = 71;
    stops_left    = 6;
    cur_level     = '0;
    lines_dirty   = 0;
    sweep_may_run = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    // clear sweep and length computation after reset
    repeat (SWEEP_WAIT) @(posedge clk);

    // max feedback, short lines: extremes and stop items
    configure(4'd15, 1'b1, 16'd8000, 1);
    send_item(make_item(CMD_FRAME, 32'd0, 32'd0));
    send_item(make_item(CMD_FRAME, SAMPLE_MAX, SAMPLE_MIN));
    send_item(make_item(CMD_FRAME, SAMPLE_MIN, SAMPLE_MAX));
    send_item(make_item(CMD_FRAME, 32'hFFFF_FFFF, 32'd1));
    send_item(make_item(CMD_FRAME, 32'd1, 32'hFFFF_FFFF));
    send_item(make_item(CMD_FRAME, SAMPLE_MAX, SAMPLE_MAX));
    send_item(make_item(CMD_FRAME, SAMPLE_MIN, SAMPLE_MIN));
    send_item(make_item(CMD_FRAME, 32'h5555_5555, 32'hAAAA_AAAA));
    send_item(make_item(CMD_STOP, 32'hAAAA_AAAA, 32'h5555_5555));
    send_item(make_item(CMD_FRAME, SAMPLE_MAX, SAMPLE_MIN));
    send_item(make_item(CMD_FRAME, SAMPLE_MIN, SAMPLE_MAX));
    send_item(make_item(CMD_STOP, 32'd0, 32'd0));
    send_item(make_item(CMD_STOP, SAMPLE_MAX, SAMPLE_MIN));
    send_item(make_item(CMD_FRAME, 32'd123456, -32'sd654321));

    // level 0 bypasses and clears
    configure(4'd0, 1'b1, 16'd8000, 0);
    send_item(make_item(CMD_FRAME, SAMPLE_MAX, SAMPLE_MIN));
    send_item(make_item(CMD_FRAME, SAMPLE_MIN, SAMPLE_MAX));
    send_item(make_item(CMD_FRAME, 32'hFFFF_FFFF, 32'd0));

    // very low rate: every line is one entry long, the two shortest rounding down to zero and raised to 1
    configure(4'd7, 1'b0, 16'd21, 1);
    send_item(make_item(CMD_FRAME, SAMPLE_MAX, SAMPLE_MIN));
    send_item(make_item(CMD_FRAME, SAMPLE_MIN, SAMPLE_MAX));
    send_item(make_item(CMD_FRAME, -32'sd8, 32'd7));
    send_item(make_item(CMD_FRAME, 32'd1, 32'd2));

    // top of the rate range, mono
    configure(4'd15, 1'b0, 16'd50000, 1);
    send_item(make_item(CMD_FRAME, SAMPLE_MAX, SAMPLE_MIN));
    send_item(make_item(CMD_FRAME, SAMPLE_MIN, SAMPLE_MAX));

    // random part, sender lightly idle and receiver mostly stalled
    configure(4'd15, 1'b1, 16'd8000, 1);
    random_frames(300);
    // level and mode change alone keep the lines
    configure(4'd3, 1'b0, 16'd8000, 0);
    random_frames(150);

    // sender mostly idle, receiver lightly stalled
    set_idling(71, 13);
    configure(4'd1, 1'b1, 16'd8000, 0);
    random_frames(200);
    configure(4'd0, 1'b0, 16'd8000, 0);
    random_frames(60);
    // rate above MAX_DELAY's reach: long lines saturate
    configure(4'd9, 1'b1, 16'hFFFF, 1);
    random_frames(200);

    // no idling on either side
    set_idling(0, 0);
    configure(4'd15, 1'b0, 16'd0, 1);
    random_frames(120);
    configure(4'd12, 1'b1, 16'd22050, 1);
    random_frames(250);
    send_item(make_item(CMD_STOP, pick_sample(), pick_sample()));

    hold_until_drained();
    repeat (TAIL_WAIT) @(posedge clk);
    if (fail_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
